[src/sync_length_frame_deframer_assert.svh]
// Assertion macros used by the deframer parser module.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[src/slfd_pkg.sv]
`default_nettype none

package slfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h94;
  localparam logic [7:0] SYNC_SECOND = 8'hC3;

  localparam logic [8:0] LIMIT_CAP   = 9'd256;
  localparam logic [8:0] LIMIT_RESET = 9'd256;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef enum logic [4:0] {
    PH_HUNT1   = 5'b00001,
    PH_HUNT2   = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_LEN_LO  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        last;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

[src/slfd_in_stage.sv]
`default_nettype none

module slfd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       advance,
  output logic            valid,
  output logic [7:0]      rx_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // The register frees up in the same cycle its word moves on.
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign valid   = valid_r;
  assign rx_byte = byte_r;

endmodule

`default_nettype wire

[src/slfd_parser.sv]
`default_nettype none
`include "sync_length_frame_deframer_assert.svh"

module slfd_parser
  import slfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic [8:0] limit,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] length_r;
  logic [15:0] length_nxt;
  logic [7:0]  count_r;
  logic [7:0]  count_nxt;
  logic [8:0]  lim_eff;
  logic [15:0] len_full;
  logic [8:0]  idx_inc;
  logic        fin;

  assign lim_eff  = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
  assign len_full = {length_r[15:8], rx_byte};
  assign idx_inc  = {1'b0, count_r} + 9'd1;
  assign fin      = {7'd0, idx_inc} >= length_r;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    res_valid  = 1'b0;
    res        = '0;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT1: begin
          if (rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          // A repeated first sync byte keeps the hunt waiting for the second.
          if (rx_byte == SYNC_SECOND) begin
            phase_nxt = PH_LEN_HI;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_LEN_HI: begin
          length_nxt = {rx_byte, 8'd0};
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          count_nxt = 8'd0;
          if (len_full == 16'd0 || len_full >= {7'd0, lim_eff}) begin
            res_valid        = 1'b1;
            res.kind         = KIND_REJECT;
            res.frame_length = len_full;
            length_nxt       = 16'd0;
            phase_nxt        = PH_HUNT1;
          end else begin
            length_nxt = len_full;
            phase_nxt  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.data_byte    = rx_byte;
          res.byte_index   = count_r;
          res.last         = fin;
          res.frame_length = length_r;
          if (fin) begin
            count_nxt  = 8'd0;
            length_nxt = 16'd0;
            phase_nxt  = PH_HUNT1;
          end else begin
            count_nxt = idx_inc[7:0];
          end
        end
        default: begin
          phase_nxt = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT1;
      length_r <= 16'd0;
      count_r  <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

  `SLFD_ASSERT_IMP(a_index_in_frame, clk, rst_n,
    res_valid && res.kind == KIND_PAYLOAD, 16'(res.byte_index) < res.frame_length)
  `SLFD_ASSERT_IMP(a_reject_length, clk, rst_n,
    res_valid && res.kind == KIND_REJECT,
    res.frame_length == 16'd0 || res.frame_length >= 16'(lim_eff))
  `SLFD_ASSERT_NEXT(a_last_rehunt, clk, rst_n, res_valid && res.last,
    phase_r == PH_HUNT1 && length_r == 16'd0 && count_r == 8'd0)

endmodule

`default_nettype wire

[src/slfd_out_stage.sv]
`default_nettype none

module slfd_out_stage
  import slfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register may load whenever it is empty or its word leaves this cycle.
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

[src/sync_length_frame_deframer.sv]
// Datapath: a word accepted into the input register is parsed as it leaves it,
// and any result it yields is captured in the result register.
// Throughput: one word per cycle; the input and result registers each stall only
// while the word ahead of them is held by a stalled consumer.
// Reset: synchronous, active low; clears both stages and the frame state and
// sets the frame length limit to 256.
`default_nettype none

module sync_length_frame_deframer
  import slfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_last,
  output logic [15:0]      out_frame_length
);

  logic [8:0] limit_r;
  logic       ready;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign fire = stage_valid && ready;

  slfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (ready),
    .valid      (stage_valid),
    .rx_byte    (stage_byte)
  );

  slfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (stage_byte),
    .limit     (limit_r),
    .res_valid (res_valid),
    .res       (res)
  );

  slfd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_data_byte    = out_res.data_byte;
  assign out_byte_index   = out_res.byte_index;
  assign out_last         = out_res.last;
  assign out_frame_length = out_res.frame_length;

endmodule

`default_nettype wire
